@@ design/bdaq_pkg.sv @@
// Package for the button debounce / auto-repeat queue block.
// Holds default register values, item kind codes, register indexes and sizes.
// No dependencies.
package bdaq_pkg;

  localparam int NUM_BUTTONS_DEF = 4;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TIME_BITS_DEF   = 32;

  localparam int REG_W  = 16;
  localparam int CODE_W = 2;
  localparam int KEY_W  = 3;

  localparam logic [15:0] DEBOUNCE_RST = 16'd150;
  localparam logic [15:0] REPEAT_RST   = 16'd50;
  localparam logic [3:0]  MODES_RST    = 4'd12;

  // item kinds carried on the input tuser
  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_EDGE = 2'd1;
  localparam logic [1:0] FUNC_POP  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_REPEAT   = 2'd1;
  localparam logic [1:0] REG_MODES    = 2'd2;

  localparam logic [KEY_W-1:0] EMPTY_CODE = 3'd4;

endpackage

@@ design/bdaq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Used for the key code queue. No dependencies.
module bdaq_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/button_debounce_autorepeat_queue_top.sv @@
// Button debounce / auto-repeat controller with a key code queue.
// Tick: accept, clock increment, then one timer per cycle through the shared
// subtractor. Edge: accept, gap, compare.
// Pop: accept, then the result is registered once the output register is free.
// Reset (rst_ni, async low) clears time, timers, queue pointers and lost flag;
// registers return to 150, 50 and 12. Queue contents are not cleared.
module button_debounce_autorepeat_queue_top
  import bdaq_pkg::*;
#(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [1:0] button, [5:2] pin_levels
  input  logic [1:0]       s_axis_tuser,   // [1:0] func
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [2:0] key_code, [3] lost
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [REG_W-1:0] cfg_data_i
);

  localparam int BtnW  = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int PtrW  = $clog2(QUEUE_DEPTH);
  localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int AluW  = TIME_BITS + 1;
  localparam logic [BtnW-1:0] LastBtn = BtnW'(NUM_BUTTONS - 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_INC,
    ST_TICK_SVC,
    ST_EDGE_GAP,
    ST_EDGE_CMP,
    ST_POP
  } state_e;

  state_e state_q;

  logic [REG_W-1:0]     debounce_q, repeat_q;
  logic [3:0]           modes_q;
  logic [TIME_BITS-1:0] now_q, gap_q;
  logic [TIME_BITS-1:0] last_q [NUM_BUTTONS];
  logic                 on_q   [NUM_BUTTONS];
  logic [REG_W-1:0]     left_q [NUM_BUTTONS];
  logic [BtnW-1:0]      btn_q;
  logic [3:0]           pins_q;
  logic [PtrW-1:0]      rd_ptr_q, wr_ptr_q;
  logic [CntW-1:0]      count_q;
  logic                 lost_q;
  logic                 pop_empty_q;
  logic                 m_valid_q;
  logic [KEY_W-1:0]     m_key_q;
  logic                 m_lost_q;

  logic                   in_acc;
  logic [1:0]             in_func;
  logic [7:0]             btn_ext;
  logic [BtnW-1:0]        in_btn;
  logic [7:0]             mode_ext, pin_ext;
  logic [NUM_BUTTONS-1:0] mode_vec, pin_vec;
  logic [REG_W-1:0]       period;
  logic [AluW-1:0]        alu_a, alu_b, alu_res;
  logic                   borrow;
  logic                   push_req, full, out_free;
  logic [CODE_W-1:0]      push_code, ram_rdata;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_func  = s_axis_tuser;
  assign btn_ext  = {6'b0, s_axis_tdata[1:0]};
  assign in_btn   = btn_ext[BtnW-1:0];
  assign mode_ext = {4'b0, modes_q};
  assign pin_ext  = {4'b0, pins_q};
  assign mode_vec = mode_ext[NUM_BUTTONS-1:0];
  assign pin_vec  = pin_ext[NUM_BUTTONS-1:0];
  assign period   = (repeat_q == '0) ? REG_W'(1) : repeat_q;
  assign full     = (count_q == FullCnt);
  assign out_free = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // Shared subtractor: clock increment, edge gap, debounce compare, timer count.
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state_q)
      ST_TICK_INC: begin
        alu_a = {1'b0, now_q};
        alu_b = {1'b0, {TIME_BITS{1'b1}}};
      end
      ST_TICK_SVC: begin
        alu_a = {{(AluW-REG_W){1'b0}}, left_q[btn_q]};
        alu_b = AluW'(1);
      end
      ST_EDGE_GAP: begin
        alu_a = {1'b0, now_q};
        alu_b = {1'b0, last_q[btn_q]};
      end
      ST_EDGE_CMP: begin
        alu_a = {{(AluW-REG_W){1'b0}}, debounce_q};
        alu_b = {1'b0, gap_q};
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
    alu_res = alu_a - alu_b;
  end

  assign borrow = alu_res[AluW-1];

  // A timer expires when its count minus one is zero (or it underflows).
  always_comb begin
    push_req = 1'b0;
    if (state_q == ST_TICK_SVC) begin
      push_req = on_q[btn_q] && (borrow || (alu_res[REG_W-1:0] == '0));
    end else if (state_q == ST_EDGE_CMP) begin
      push_req = borrow && !mode_vec[btn_q];
    end
  end

  assign push_code = CODE_W'(btn_q);

  bdaq_ram #(
    .WIDTH(CODE_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .we_i   (push_req && !full),
    .waddr_i(wr_ptr_q),
    .wdata_i(push_code),
    .re_i   (in_acc && (in_func == FUNC_POP)),
    .raddr_i(rd_ptr_q),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      debounce_q  <= DEBOUNCE_RST;
      repeat_q    <= REPEAT_RST;
      modes_q     <= MODES_RST;
      now_q       <= '0;
      gap_q       <= '0;
      btn_q       <= '0;
      pins_q      <= '0;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      count_q     <= '0;
      lost_q      <= 1'b0;
      pop_empty_q <= 1'b0;
      m_valid_q   <= 1'b0;
      m_key_q     <= '0;
      m_lost_q    <= 1'b0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        last_q[i] <= '0;
        on_q[i]   <= 1'b0;
        left_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_DEBOUNCE: debounce_q <= cfg_data_i;
          REG_REPEAT:   repeat_q   <= cfg_data_i;
          REG_MODES:    modes_q    <= cfg_data_i[3:0];
          default:      ;
        endcase
      end

      // drop the taken word unless a pop refills the register this cycle
      if (m_valid_q && m_axis_tready && (state_q != ST_POP)) begin
        m_valid_q <= 1'b0;
      end

      // queue push, shared by timer service and one-shot edges
      if (push_req) begin
        if (full) begin
          lost_q <= 1'b1;
        end else begin
          wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
          count_q  <= count_q + CntW'(1);
        end
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            pins_q <= s_axis_tdata[5:2];
            unique case (in_func)
              FUNC_TICK: begin
                btn_q   <= '0;
                state_q <= ST_TICK_INC;
              end
              FUNC_EDGE: begin
                if (btn_ext < 8'(NUM_BUTTONS)) begin
                  btn_q   <= in_btn;
                  state_q <= ST_EDGE_GAP;
                end
              end
              FUNC_POP: begin
                pop_empty_q <= (count_q == '0);
                state_q     <= ST_POP;
              end
              default: ;
            endcase
          end
        end
        ST_TICK_INC: begin
          now_q   <= alu_res[TIME_BITS-1:0];
          state_q <= ST_TICK_SVC;
        end
        ST_TICK_SVC: begin
          if (on_q[btn_q]) begin
            if (!push_req) begin
              left_q[btn_q] <= alu_res[REG_W-1:0];
            end else if (!pin_vec[btn_q]) begin
              on_q[btn_q]   <= 1'b0;
              left_q[btn_q] <= '0;
            end else begin
              left_q[btn_q] <= period;
            end
          end
          if (btn_q == LastBtn) begin
            state_q <= ST_IDLE;
          end else begin
            btn_q <= btn_q + BtnW'(1);
          end
        end
        ST_EDGE_GAP: begin
          gap_q   <= alu_res[TIME_BITS-1:0];
          state_q <= ST_EDGE_CMP;
        end
        ST_EDGE_CMP: begin
          // borrow means gap > debounce: the edge counts
          if (borrow && mode_vec[btn_q]) begin
            on_q[btn_q]   <= 1'b1;
            left_q[btn_q] <= period;
          end
          last_q[btn_q] <= now_q;
          state_q       <= ST_IDLE;
        end
        ST_POP: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_key_q   <= pop_empty_q ? EMPTY_CODE : {1'b0, ram_rdata};
            m_lost_q  <= lost_q;
            lost_q    <= 1'b0;
            if (!pop_empty_q) begin
              rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
              count_q  <= count_q - CntW'(1);
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0, m_lost_q, m_key_q};

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count above depth");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == FullCnt) |-> (rd_ptr_q == wr_ptr_q))
    else $error("queue pointers disagree with count");

  a_lost_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP && out_free) |=> !lost_q)
    else $error("lost flag not cleared by pop");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_POP))
    else $error("result word raised outside pop");
`endif

endmodule
